/* sv/cbm_pkg.sv */
// cbm_pkg: shared types and constants for the cartridge bank mapper
// no dependencies; imported by cartridge_bank_mapper_with_line_irq_top and the testbench

package cbm_pkg;

  // sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  // map_kind codes
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_PRG  = 2'd1,
    KIND_CHR  = 2'd2
  } map_kind_t;

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // configuration register indexes (paddr bit 2)
  localparam logic REG_PRG_COUNT = 1'b0;
  localparam logic REG_CHR_COUNT = 1'b1;

  localparam logic [9:0]  PRG_COUNT_RESET = 10'd2;
  localparam logic [11:0] CHR_COUNT_RESET = 12'd8;

  localparam int unsigned NUM_BANK_REGS = 11;
  localparam int unsigned NUM_PRG_REGS  = 3;

  localparam logic [15:0] IRQ_STEP = 16'd113;

  // address map
  localparam logic [3:0]  TOP_PRG_A   = 4'h8;
  localparam logic [3:0]  TOP_PRG_B   = 4'h9;
  localparam logic [3:0]  TOP_CHR_LO  = 4'hA;
  localparam logic [3:0]  TOP_CHR_HI  = 4'hD;
  localparam logic [13:0] ADDR_LATCH  = 14'h3800;  // 0xE000..0xE003 >> 2
  localparam logic [15:0] ADDR_CNT    = 16'hF000;
  localparam logic [15:0] ADDR_ENABLE = 16'hF001;
  localparam logic [15:0] ADDR_MIRROR = 16'hF002;

  localparam logic [1:0] MIRROR_INVALID = 2'd3;

endpackage

/* sv/cartridge_bank_mapper_with_line_irq_top.sv */
// a bank register write is accepted, passes through 8 restoring modulo steps in
// the single shared modulo step unit, then its result is loaded; any other beat is
// accepted and its result loaded; the input stays closed until the result of the
// current beat is loaded, so one beat is in the mapper at a time; a stalled result holds
// the sequencer in its result state and keeps the input closed
// reset (rst, synchronous, active high): bank registers, reload latch, counter
// and enable go to zero, bank counts to 2 and 8, output channel empty

module cartridge_bank_mapper_with_line_irq_top
  import cbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // address[15:0], wdata[23:16]
  input  logic        s_tuser,   // operation[0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // slot[2:0], bank[10:3], mirror_set[11],
                                 // mirror_mode[13:12], irq_request[14], irq_count[30:15]
  output logic [1:0]  m_tuser,   // map_kind[1:0]
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [9:0]  prg_bank_count;
  logic [11:0] chr_bank_count;

  // mapper state
  logic [7:0]  bank_regs [NUM_BANK_REGS];
  logic [15:0] reload_latch;
  logic [15:0] line_counter;
  logic        irq_enabled;

  state_t state;

  // pending result fields, captured when the beat is taken
  map_kind_t   pend_kind;
  logic [2:0]  pend_slot;
  logic        pend_mset;
  logic [1:0]  pend_mmode;
  logic        pend_irq;
  logic [15:0] pend_count;

  // shared modulo unit: restoring, one quotient bit per cycle
  logic [7:0]  div_val;     // dividend, shifted out msb first
  logic [7:0]  div_orig;    // unreduced value for a zero modulus
  logic [11:0] div_mod;
  logic [8:0]  div_rem;
  logic [2:0]  div_step;
  logic [8:0]  div_trial;
  logic        div_ge;

  // output register
  logic        out_valid;
  map_kind_t   out_kind;
  logic [2:0]  out_slot;
  logic [7:0]  out_bank;
  logic        out_mset;
  logic [1:0]  out_mmode;
  logic        out_irq;
  logic [15:0] out_count;

  // input beat fields
  logic        in_op;
  logic [15:0] in_addr;
  logic [7:0]  in_data;
  logic [3:0]  in_nib;
  logic        in_take;

  assign in_op   = s_tuser;
  assign in_addr = s_tdata[15:0];
  assign in_data = s_tdata[23:16];
  assign in_nib  = in_data[3:0];

  assign s_tready = (state == ST_IDLE);
  assign in_take  = s_tvalid && s_tready;

  // bank register address decode
  logic [3:0] top;
  logic [3:0] dec_idx;
  logic       dec_hit;
  logic       dec_high;

  assign top      = in_addr[15:12];
  assign dec_high = in_addr[0];

  always_comb begin
    dec_hit = 1'b0;
    dec_idx = 4'd0;
    if (in_addr[11:2] == 10'd0) begin
      if (top == TOP_PRG_A) begin
        dec_hit = 1'b1;
        dec_idx = {3'd0, in_addr[1]};
      end else if (top == TOP_PRG_B) begin
        dec_hit = !in_addr[1];
        dec_idx = 4'd2;
      end else if (top >= TOP_CHR_LO && top <= TOP_CHR_HI) begin
        dec_hit = 1'b1;
        // 3 + 2 * (top - 0xA) + addr[1]
        dec_idx = 4'd3 + {top[2:0] - 3'd2, 1'b0} + {3'd0, in_addr[1]};
      end
    end
  end

  // new bank register value
  logic [7:0] old_bank;
  logic [7:0] new_bank;
  logic       is_prg;

  assign old_bank = bank_regs[dec_idx];
  assign new_bank = dec_high ? {in_nib, old_bank[3:0]} : {old_bank[7:4], in_nib};
  assign is_prg   = (dec_idx < 4'(NUM_PRG_REGS));

  // result fields and state updates for the beat on the input
  map_kind_t   kind_next;
  logic [2:0]  slot_next;
  logic        mset_next;
  logic [1:0]  mmode_next;
  logic        irq_next;
  logic [15:0] count_next;
  logic [15:0] latch_next;
  logic        enable_next;

  always_comb begin
    kind_next   = KIND_NONE;
    slot_next   = 3'd0;
    mset_next   = 1'b0;
    mmode_next  = 2'd0;
    irq_next    = 1'b0;
    count_next  = line_counter;
    latch_next  = reload_latch;
    enable_next = irq_enabled;
    if (in_op == OP_TICK) begin
      if (irq_enabled) begin
        if (line_counter <= IRQ_STEP) begin
          irq_next    = 1'b1;
          count_next  = 16'd0;
          enable_next = 1'b0;
        end else begin
          count_next = line_counter - IRQ_STEP;
        end
      end
    end else if (dec_hit) begin
      if (is_prg) begin
        kind_next = KIND_PRG;
        slot_next = dec_idx[2:0];
      end else begin
        kind_next = KIND_CHR;
        slot_next = 3'(dec_idx - 4'(NUM_PRG_REGS));
      end
    end else if (in_addr[15:2] == ADDR_LATCH) begin
      unique case (in_addr[1:0])
        2'd0:    latch_next[3:0]   = in_nib;
        2'd1:    latch_next[7:4]   = in_nib;
        2'd2:    latch_next[11:8]  = in_nib;
        default: latch_next[15:12] = in_nib;
      endcase
    end else if (in_addr == ADDR_CNT) begin
      count_next = in_data[0] ? reload_latch : 16'd0;
    end else if (in_addr == ADDR_ENABLE) begin
      enable_next = in_data[0];
    end else if (in_addr == ADDR_MIRROR) begin
      if (in_data[1:0] != MIRROR_INVALID) begin
        mset_next  = 1'b1;
        mmode_next = in_data[1:0];
      end
    end
  end

  // modulo step
  assign div_trial = {div_rem[7:0], div_val[7]};
  assign div_ge    = ({3'd0, div_trial} >= div_mod);

  // output register is free or drains this cycle
  logic out_free;
  logic out_load;
  assign out_free = !out_valid || m_tready;
  assign out_load = (state == ST_DONE) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      reload_latch <= 16'd0;
      line_counter <= 16'd0;
      irq_enabled  <= 1'b0;
      for (int i = 0; i < NUM_BANK_REGS; i++) begin
        bank_regs[i] <= 8'd0;
      end
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            pend_kind    <= kind_next;
            pend_slot    <= slot_next;
            pend_mset    <= mset_next;
            pend_mmode   <= mmode_next;
            pend_irq     <= irq_next;
            pend_count   <= count_next;
            line_counter <= count_next;
            reload_latch <= latch_next;
            irq_enabled  <= enable_next;
            div_step     <= 3'd0;
            div_rem      <= 9'd0;
            if (in_op == OP_WRITE && dec_hit) begin
              bank_regs[dec_idx] <= new_bank;
              div_val  <= new_bank;
              div_orig <= new_bank;
              div_mod  <= is_prg ? {2'd0, prg_bank_count} : chr_bank_count;
              state    <= ST_DIV;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_DIV: begin
          // one restoring step per cycle, msb first
          div_val  <= {div_val[6:0], 1'b0};
          div_rem  <= div_ge ? (div_trial - div_mod[8:0]) : div_trial;
          div_step <= div_step + 3'd1;
          if (div_step == 3'd7) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_kind  <= pend_kind;
            out_slot  <= pend_slot;
            out_mset  <= pend_mset;
            out_mmode <= pend_mmode;
            out_irq   <= pend_irq;
            out_count <= pend_count;
            if (pend_kind == KIND_NONE) begin
              out_bank <= 8'd0;
            end else if (div_mod == 12'd0) begin
              out_bank <= div_orig;  // zero count: no reduction
            end else begin
              out_bank <= div_rem[7:0];
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tdata  = {1'b0, out_count, out_irq, out_mmode, out_mset, out_bank, out_slot};

  // configuration port, register picked by paddr bit 2
  logic cfg_write;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_count <= PRG_COUNT_RESET;
      chr_bank_count <= CHR_COUNT_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_PRG_COUNT: prg_bank_count <= pwdata[9:0];
        default:       chr_bank_count <= pwdata[11:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PRG_COUNT: prdata = {22'd0, prg_bank_count};
      default:       prdata = {20'd0, chr_bank_count};
    endcase
  end

  // low address bits alias onto the two registers
  logic [1:0] unused_paddr;
  assign unused_paddr = paddr[1:0];

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// testbench: self-checking stream test of cartridge_bank_mapper_with_line_irq_top
// needs cbm_pkg and the mapper rtl; runs a directed table, then random bus traffic

module testbench;
  import cbm_pkg::*;

  // mirroring codes as reported in mirror_mode
  localparam logic [1:0] MIR_HORZ      = 2'd0;
  localparam logic [1:0] MIR_VERT      = 2'd1;
  localparam logic [1:0] MIR_SINGLE_LO = 2'd2;

  // cycles with no beat on either stream before the run is declared hung
  localparam int STALL_LIMIT = 4000;
  // receiver hold-off used once to back the mapper up into its input
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_BEATS = 180;

  typedef struct packed {
    logic        op;
    logic [15:0] addr;
    logic [7:0]  wd;
  } beat_t;

  typedef struct packed {
    map_kind_t   kind;
    logic [2:0]  slot;
    logic [7:0]  bank;
    logic        mset;
    logic [1:0]  mmode;
    logic        irq;
    logic [15:0] count;
  } map_result_t;

  typedef struct packed {
    beat_t       b;
    logic        typed;
    map_result_t want;
  } dir_row_t;

  localparam map_result_t NO_RES = '0;

  // directed table; rows with typed set carry the answer, the rest go to the predictor.
  // runs with the reset bank counts (2 program, 8 character)
  localparam dir_row_t DIR_ROWS [28] = '{
    // tick straight after reset: counter disabled, nothing moves
    '{'{OP_TICK,  16'hFFFF, 8'hFF}, 1'b1, NO_RES},
    // unmapped addresses at both ends of the map
    '{'{OP_WRITE, 16'h0000, 8'hFF}, 1'b1, NO_RES},
    '{'{OP_WRITE, 16'hFFFF, 8'hFF}, 1'b1, NO_RES},
    // program slot 0 nibbles, 0x0f and 0xff both reduce to 1 modulo 2
    '{'{OP_WRITE, 16'h8000, 8'h0F}, 1'b1,
      '{KIND_PRG, 3'd0, 8'd1, 1'b0, MIR_HORZ, 1'b0, 16'd0}},
    '{'{OP_WRITE, 16'h8001, 8'hFF}, 1'b1,
      '{KIND_PRG, 3'd0, 8'd1, 1'b0, MIR_HORZ, 1'b0, 16'd0}},
    '{'{OP_WRITE, 16'h8003, 8'hA5}, 1'b0, NO_RES},
    '{'{OP_WRITE, 16'h9001, 8'h3C}, 1'b0, NO_RES},
    // 0x9000 block has only two nibble addresses
    '{'{OP_WRITE, 16'h9002, 8'hFF}, 1'b1, NO_RES},
    '{'{OP_WRITE, 16'hA000, 8'hFF}, 1'b0, NO_RES},
    '{'{OP_WRITE, 16'hB003, 8'hF0}, 1'b0, NO_RES},
    '{'{OP_WRITE, 16'hD003, 8'hFF}, 1'b0, NO_RES},
    // reload latch = 0x00ff, load counter, enable, count down to the interrupt
    '{'{OP_WRITE, 16'hE000, 8'h0F}, 1'b0, NO_RES},
    '{'{OP_WRITE, 16'hE001, 8'hFF}, 1'b0, NO_RES},
    '{'{OP_WRITE, 16'hF000, 8'h01}, 1'b1,
      '{KIND_NONE, 3'd0, 8'd0, 1'b0, MIR_HORZ, 1'b0, 16'd255}},
    '{'{OP_WRITE, 16'hF001, 8'h01}, 1'b0, NO_RES},
    '{'{OP_TICK,  16'h0000, 8'h00}, 1'b0, NO_RES},
    '{'{OP_TICK,  16'h8000, 8'hFF}, 1'b0, NO_RES},
    '{'{OP_TICK,  16'hF000, 8'h01}, 1'b1,
      '{KIND_NONE, 3'd0, 8'd0, 1'b0, MIR_HORZ, 1'b1, 16'd0}},
    // interrupt disabled itself, next tick does nothing
    '{'{OP_TICK,  16'hFFFF, 8'hFF}, 1'b1, NO_RES},
    // counter exactly at the step size fires on the first tick
    '{'{OP_WRITE, 16'hE000, 8'h01}, 1'b0, NO_RES},
    '{'{OP_WRITE, 16'hE001, 8'h07}, 1'b0, NO_RES},
    '{'{OP_WRITE, 16'hF000, 8'hFF}, 1'b1,
      '{KIND_NONE, 3'd0, 8'd0, 1'b0, MIR_HORZ, 1'b0, 16'd113}},
    '{'{OP_WRITE, 16'hF001, 8'hFF}, 1'b0, NO_RES},
    '{'{OP_TICK,  16'h0000, 8'h00}, 1'b1,
      '{KIND_NONE, 3'd0, 8'd0, 1'b0, MIR_HORZ, 1'b1, 16'd0}},
    // mirroring: each legal code, and the illegal code is dropped
    '{'{OP_WRITE, 16'hF002, 8'h00}, 1'b1,
      '{KIND_NONE, 3'd0, 8'd0, 1'b1, MIR_HORZ, 1'b0, 16'd0}},
    '{'{OP_WRITE, 16'hF002, 8'h02}, 1'b1,
      '{KIND_NONE, 3'd0, 8'd0, 1'b1, MIR_SINGLE_LO, 1'b0, 16'd0}},
    '{'{OP_WRITE, 16'hF002, 8'h03}, 1'b1, NO_RES},
    '{'{OP_WRITE, 16'hF002, 8'hFD}, 1'b0, NO_RES}
  };

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // address[15:0], wdata[23:16]
  logic        s_tuser;   // operation[0]
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // slot[2:0], bank[10:3], mirror_set[11],
                          // mirror_mode[13:12], irq_request[14], irq_count[30:15]
  logic [1:0]  m_tuser;   // map_kind[1:0]
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // predictor state, mirrors the mapper's registers
  logic [7:0]  bank_file [NUM_BANK_REGS];
  logic [15:0] latch_val;
  logic [15:0] line_cnt;
  logic        irq_on;
  logic [9:0]  prg_cfg;
  logic [11:0] chr_cfg;

  map_result_t pending_maps [$];
  int          fails;
  int          beats_sent;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          hold_left;

  cartridge_bank_mapper_with_line_irq_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // a zero bank count means no reduction at all
  function automatic logic [7:0] bank_fold(logic [7:0] v, logic [11:0] m);
    if (m == '0) return v;
    return 8'(v % m);
  endfunction

  // advance the predicted mapper state by one beat and return the result it gives
  function automatic map_result_t predict_map(beat_t b);
    map_result_t r;
    logic [3:0]  top;
    logic [11:0] low;
    logic [7:0]  v;
    int          idx;
    int          sh;
    r   = '0;
    top = b.addr[15:12];
    low = b.addr[11:0];
    idx = -1;
    if (b.op == OP_TICK) begin
      if (irq_on) begin
        if (line_cnt <= IRQ_STEP) begin
          r.irq    = 1'b1;
          line_cnt = '0;
          irq_on   = 1'b0;
        end else begin
          line_cnt = line_cnt - IRQ_STEP;
        end
      end
    end else begin
      // bank decode: only offsets 0..3 inside each 4 KiB window
      if (low <= 12'd3) begin
        if (top == TOP_PRG_A) begin
          idx = int'(low[1]);
        end else if (top == TOP_PRG_B && low <= 12'd1) begin
          idx = 2;
        end else if (top >= TOP_CHR_LO && top <= TOP_CHR_HI) begin
          idx = NUM_PRG_REGS + 2 * int'(top - TOP_CHR_LO) + int'(low[1]);
        end
      end
      if (idx >= 0) begin
        v = bank_file[idx];
        if (low[0]) v[7:4] = b.wd[3:0];
        else        v[3:0] = b.wd[3:0];
        bank_file[idx] = v;
        if (idx < int'(NUM_PRG_REGS)) begin
          r.kind = KIND_PRG;
          r.slot = 3'(idx);
          r.bank = bank_fold(v, {2'b00, prg_cfg});
        end else begin
          r.kind = KIND_CHR;
          r.slot = 3'(idx - int'(NUM_PRG_REGS));
          r.bank = bank_fold(v, chr_cfg);
        end
      end else if (b.addr[15:2] == ADDR_LATCH) begin
        sh = int'(b.addr[1:0]) * 4;
        latch_val[sh +: 4] = b.wd[3:0];
      end else if (b.addr == ADDR_CNT) begin
        line_cnt = b.wd[0] ? latch_val : '0;
      end else if (b.addr == ADDR_ENABLE) begin
        irq_on = b.wd[0];
      end else if (b.addr == ADDR_MIRROR && b.wd[1:0] != MIRROR_INVALID) begin
        r.mset  = 1'b1;
        r.mmode = b.wd[1:0];
      end
    end
    r.count = line_cnt;
    return r;
  endfunction

  function automatic string res_text(map_result_t r);
    return $sformatf("kind=%0d slot=%0d bank=%0d mset=%0b mode=%0d irq=%0b count=%0d",
                     r.kind, r.slot, r.bank, r.mset, r.mmode, r.irq, r.count);
  endfunction

  // first ten failures are printed, the rest only counted
  task automatic note_fail(string msg);
    if (fails < 10) $display("%s", msg);
    fails++;
  endtask

  // mix of bus traffic: mostly mapped registers, some ticks, some noise
  function automatic beat_t rand_beat();
    beat_t      b;
    int         pick;
    logic [3:0] top;
    logic [1:0] low;
    b.op   = OP_WRITE;
    b.wd   = 8'($urandom_range(255));
    b.addr = 16'($urandom_range(65535));
    pick   = $urandom_range(99);
    if (pick < 40) begin
      top = 4'($urandom_range(8, 13));
      low = (top == TOP_PRG_B) ? 2'($urandom_range(1)) : 2'($urandom_range(3));
      b.addr = {top, 10'd0, low};
    end else if (pick < 55) begin
      b.op = OP_TICK;
    end else if (pick < 65) begin
      b.addr = ADDR_MIRROR;
    end else if (pick < 70) begin
      b.addr = ADDR_CNT;
    end else if (pick < 75) begin
      b.addr = ADDR_ENABLE;
    end else if (pick < 85) begin
      b.addr = {ADDR_LATCH, 2'($urandom_range(3))};
    end
    // remaining picks keep the fully random address
    return b;
  endfunction

  // offer one beat with random sender gaps; predict once it is taken
  task automatic push_beat(beat_t b, logic typed, map_result_t typed_res);
    map_result_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b.wd, b.addr};
    s_tuser  <= b.op;
    do @(posedge clk); while (!s_tready);
    r = predict_map(b);
    pending_maps.push_back(typed ? typed_res : r);
    beats_sent++;
  endtask

  // stop sending until every expected result is back, then let the pipe settle
  task automatic drain_maps();
    s_tvalid <= 1'b0;
    while (pending_maps.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // apb write followed by a read back of the same register
  task automatic cfg_set(logic idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_PRG_COUNT) prg_cfg = val[9:0];
    else                      chr_cfg = val[11:0];
    // psel stays high straight into the read setup
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== val)
      note_fail($sformatf("reg %0d read back: expected %0d actual %0d", idx, val, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // result checker: each result beat against the oldest prediction
  initial begin : result_check
    map_result_t got;
    map_result_t want;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got.kind  = map_kind_t'(m_tuser);
        got.slot  = m_tdata[2:0];
        got.bank  = m_tdata[10:3];
        got.mset  = m_tdata[11];
        got.mmode = m_tdata[13:12];
        got.irq   = m_tdata[14];
        got.count = m_tdata[30:15];
        if (pending_maps.size() == 0) begin
          note_fail($sformatf("result with none expected: %s", res_text(got)));
        end else begin
          want = pending_maps.pop_front();
          if (got !== want)
            note_fail($sformatf("mismatch: expected %s actual %s",
                                res_text(want), res_text(got)));
        end
      end
    end
  end

  // watchdog: too long with no beat on either side means the mapper hung
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  // main sequence
  initial begin
    int          p;
    int          k;
    int          n;
    int          target;
    logic [15:0] reload;
    logic [9:0]  prg_v;
    logic [11:0] chr_v;
    beat_t       b;

    // all inputs known from time zero
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= OP_WRITE;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;

    fails       = 0;
    beats_sent  = 0;
    hold_left   = 0;
    tx_idle_pct = 27;
    rx_idle_pct = 82;
    bank_file   = '{default: '0};
    latch_val   = '0;
    line_cnt    = '0;
    irq_on      = 1'b0;
    prg_cfg     = PRG_COUNT_RESET;
    chr_cfg     = CHR_COUNT_RESET;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table at the reset bank counts
    foreach (DIR_ROWS[i]) push_beat(DIR_ROWS[i].b, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    drain_maps();

    // random phases, each with its own bank counts
    for (p = 0; p < 6; p++) begin
      // sender-light/receiver-heavy idling, then the reverse, then none
      if (p < 2) begin
        tx_idle_pct = 27;
        rx_idle_pct = 82;
      end else if (p < 4) begin
        tx_idle_pct = 82;
        rx_idle_pct = 27;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (p)
        0: begin prg_v = 10'd1;   chr_v = 12'd1;    end
        1: begin prg_v = 10'd512; chr_v = 12'd2048; end
        2: begin prg_v = 10'd0;   chr_v = 12'd0;    end  // no reduction
        3: begin prg_v = 10'h3FF; chr_v = 12'hFFF;  end
        4: begin
          prg_v = 10'($urandom_range(1, 512));
          chr_v = 12'($urandom_range(1, 2048));
        end
        default: begin
          prg_v = 10'($urandom_range(3, 40));
          chr_v = 12'($urandom_range(3, 40));
        end
      endcase
      cfg_set(REG_PRG_COUNT, {22'd0, prg_v});
      cfg_set(REG_CHR_COUNT, {20'd0, chr_v});

      // long receiver hold-off while the sender keeps offering beats
      if (p == 4) hold_left = HOLD_CYCLES;

      target = beats_sent + PHASE_BEATS;
      while (beats_sent < target) begin
        if ($urandom_range(99) < 60) begin
          // interrupt program: load latch, load counter, enable, then mostly ticks
          reload = ($urandom_range(9) == 0) ? 16'($urandom_range(65535))
                                            : 16'($urandom_range(1400));
          for (n = 0; n < 4; n++) begin
            b.op   = OP_WRITE;
            b.addr = {ADDR_LATCH, 2'(n)};
            b.wd   = {4'($urandom_range(15)), reload[n*4 +: 4]};
            push_beat(b, 1'b0, NO_RES);
          end
          b.addr = ADDR_CNT;
          b.wd   = {7'($urandom_range(127)), 1'b1};
          push_beat(b, 1'b0, NO_RES);
          b.addr = ADDR_ENABLE;
          b.wd   = {7'($urandom_range(127)), 1'b1};
          push_beat(b, 1'b0, NO_RES);
          k = $urandom_range(2, 14);
          for (n = 0; n < k; n++) begin
            b = rand_beat();
            if ($urandom_range(99) < 70) b.op = OP_TICK;
            push_beat(b, 1'b0, NO_RES);
          end
        end else begin
          k = $urandom_range(3, 10);
          for (n = 0; n < k; n++) push_beat(rand_beat(), 1'b0, NO_RES);
        end
        // now and then the sender waits for the mapper to empty out
        if ($urandom_range(49) == 0) drain_maps();
      end
      drain_maps();
    end

    if (pending_maps.size() != 0)
      note_fail($sformatf("%0d expected results never arrived", pending_maps.size()));
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
